/* rtl/core/depthwise_conv3x3_stream_unit_defines.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the depthwise 3x3 stream unit
// Shared property wrappers on clk; DWC3_ASSERT is off during the active-low asynchronous reset.
// ---------------------------------------------------------------------------
`ifndef DEPTHWISE_CONV3X3_STREAM_UNIT_DEFINES_SVH
`define DEPTHWISE_CONV3X3_STREAM_UNIT_DEFINES_SVH

// checked only out of reset
`define DWC3_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked on every edge, reset included
`define DWC3_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/dwc3_pkg.sv */
// ---------------------------------------------------------------------------
// dwc3_pkg
// Types and constants of the depthwise 3x3 stream unit.
// ---------------------------------------------------------------------------
package dwc3_pkg;

	localparam int DWC3_MAX_WIDTH  = 1024;
	localparam int DWC3_MAX_HEIGHT = 1024;
	localparam int KERNEL_SIZE     = 3;
	localparam int TAPS            = KERNEL_SIZE * KERNEL_SIZE;

	localparam int PIX_W  = 16;
	localparam int PROD_W = 32;
	localparam int ROW_W  = 34;
	localparam int ACC_W  = 36;
	localparam int FRAC_SHIFT = 12;
	localparam int Q_W    = ACC_W - FRAC_SHIFT;

	typedef enum logic [2:0] {
		REG_WEIGHT_ROW0 = 3'd0,
		REG_WEIGHT_ROW1 = 3'd1,
		REG_WEIGHT_ROW2 = 3'd2,
		REG_BIAS        = 3'd3,
		REG_WIDTH       = 3'd4,
		REG_HEIGHT      = 3'd5,
		REG_STRIDE      = 3'd6,
		REG_ACTIVATION  = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [TAPS-1:0][PIX_W-1:0] weight;
		logic [31:0]                bias;
		logic [7:0]                 act;
	} coef_t;

	typedef struct packed {
		logic [TAPS-1:0][PIX_W-1:0] taps;
		logic                       last;
	} win_t;

endpackage

/* rtl/core/depthwise_conv3x3_stream_unit.sv */
// ---------------------------------------------------------------------------
// depthwise_conv3x3_stream_unit
// Path: line-buffer register, then the product, row-sum, rounding and output registers.
// Throughput: one pixel per cycle when not stalled; each line store: a read and a write per cycle.
// Reset: registers to defaults, counters and window cleared; line stores are not cleared.
// ---------------------------------------------------------------------------
module depthwise_conv3x3_stream_unit
	import dwc3_pkg::*;
#(
	parameter int MAX_WIDTH  = DWC3_MAX_WIDTH,
	parameter int MAX_HEIGHT = DWC3_MAX_HEIGHT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [47:0] cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [15:0] pixel
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [15:0] result_value
	output logic        m_axis_tlast    // plane_last
);

	logic [2:0][47:0] weight_row_q;
	logic [31:0]      bias_q;
	logic [10:0]      width_q, height_q;
	logic             stride_q;
	logic [7:0]       act_q;
	coef_t            coef;
	win_t             win;
	logic             win_valid, win_ready;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_row_q <= '0;
			bias_q       <= '0;
			width_q      <= 11'd3;
			height_q     <= 11'd3;
			stride_q     <= 1'b0;
			act_q        <= 8'hff;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_WEIGHT_ROW0: weight_row_q[0] <= cfg_data;
				REG_WEIGHT_ROW1: weight_row_q[1] <= cfg_data;
				REG_WEIGHT_ROW2: weight_row_q[2] <= cfg_data;
				REG_BIAS:        bias_q   <= cfg_data[31:0];
				REG_WIDTH:       width_q  <= cfg_data[10:0];
				REG_HEIGHT:      height_q <= cfg_data[10:0];
				REG_STRIDE:      stride_q <= cfg_data[0];
				REG_ACTIVATION:  act_q    <= cfg_data[7:0];
			endcase
		end
	end

	always_comb begin
		for (int r = 0; r < KERNEL_SIZE; r++) begin
			for (int c = 0; c < KERNEL_SIZE; c++) begin
				coef.weight[KERNEL_SIZE*r+c] = weight_row_q[r][PIX_W*c +: PIX_W];
			end
		end
		coef.bias = bias_q;
		coef.act  = act_q;
	end

	dwc3_linebuf #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_linebuf (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.in_pixel     (s_axis_tdata),
		.plane_width  (width_q),
		.plane_height (height_q),
		.stride_two   (stride_q),
		.win_valid    (win_valid),
		.win_ready    (win_ready),
		.win          (win)
	);

	dwc3_mac u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.win_valid (win_valid),
		.win_ready (win_ready),
		.win       (win),
		.coef      (coef),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_value (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

endmodule

/* rtl/core/dwc3_ram.sv */
// ---------------------------------------------------------------------------
// dwc3_ram
// Simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module dwc3_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* rtl/core/dwc3_linebuf.sv */
// ---------------------------------------------------------------------------
// dwc3_linebuf
// Raster counters, two line-store RAMs and the window registers.
// ---------------------------------------------------------------------------
`include "depthwise_conv3x3_stream_unit_defines.svh"

module dwc3_linebuf
	import dwc3_pkg::*;
#(
	parameter int MAX_WIDTH  = DWC3_MAX_WIDTH,
	parameter int MAX_HEIGHT = DWC3_MAX_HEIGHT
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [PIX_W-1:0] in_pixel,
	input  logic [10:0]      plane_width,
	input  logic [10:0]      plane_height,
	input  logic             stride_two,
	output logic             win_valid,
	input  logic             win_ready,
	output win_t             win
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);

	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [31:0]   w_clamp, h_clamp;
	logic [CW-1:0] w_last, last_c;
	logic [RW-1:0] h_last, last_r;
	logic          accept, adv1, emit;

	logic                   v1_q;
	logic                   emit_s1, last_s1;
	logic [CW-1:0]          ci_s1;
	logic [PIX_W-1:0]       px_s1;
	logic [5:0][PIX_W-1:0]  win_q;
	logic [PIX_W-1:0]       rd_a, rd_b;

	always_comb begin
		if (plane_width < 11'd3) begin
			w_clamp = 32'd3;
		end else if (32'(plane_width) > 32'(MAX_WIDTH)) begin
			w_clamp = 32'(MAX_WIDTH);
		end else begin
			w_clamp = 32'(plane_width);
		end
		if (plane_height < 11'd3) begin
			h_clamp = 32'd3;
		end else if (32'(plane_height) > 32'(MAX_HEIGHT)) begin
			h_clamp = 32'(MAX_HEIGHT);
		end else begin
			h_clamp = 32'(plane_height);
		end
		w_last = CW'(w_clamp - 32'd1);
		h_last = RW'(h_clamp - 32'd1);
		// stride two ends on the last even position
		last_c = stride_two ? {w_last[CW-1:1], 1'b0} : w_last;
		last_r = stride_two ? {h_last[RW-1:1], 1'b0} : h_last;
		emit = (row_q >= RW'(2)) && (col_q >= CW'(2)) &&
			!(stride_two && (row_q[0] || col_q[0]));
	end

	assign adv1     = v1_q && (!emit_s1 || win_ready);
	assign in_ready = !v1_q || adv1;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			v1_q  <= 1'b0;
			win_q <= '0;
		end else begin
			if (accept) begin
				v1_q <= 1'b1;
				if (col_q >= w_last) begin
					col_q <= '0;
					row_q <= (row_q >= h_last) ? '0 : row_q + RW'(1);
				end else begin
					col_q <= col_q + CW'(1);
				end
			end else if (adv1) begin
				v1_q <= 1'b0;
			end
			if (adv1) begin
				win_q[0] <= win_q[1];
				win_q[1] <= rd_b;
				win_q[2] <= win_q[3];
				win_q[3] <= rd_a;
				win_q[4] <= win_q[5];
				win_q[5] <= px_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1   <= in_pixel;
			ci_s1   <= col_q;
			emit_s1 <= emit;
			last_s1 <= (col_q == last_c) && (row_q == last_r);
		end
	end

	dwc3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_store_a (
		.clk   (clk),
		.we    (adv1),
		.waddr (ci_s1),
		.wdata (px_s1),
		.re    (accept),
		.raddr (col_q),
		.rdata (rd_a)
	);

	dwc3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_store_b (
		.clk   (clk),
		.we    (adv1),
		.waddr (ci_s1),
		.wdata (rd_a),
		.re    (accept),
		.raddr (col_q),
		.rdata (rd_b)
	);

	assign win_valid = v1_q && emit_s1;
	always_comb begin
		win.taps[0] = win_q[0];
		win.taps[1] = win_q[1];
		win.taps[2] = rd_b;
		win.taps[3] = win_q[2];
		win.taps[4] = win_q[3];
		win.taps[5] = rd_a;
		win.taps[6] = win_q[4];
		win.taps[7] = win_q[5];
		win.taps[8] = px_s1;
		win.last    = last_s1;
	end

	// write-back and the next read never hit the same column
	`DWC3_ASSERT(a_no_rw_collision, (accept && adv1) |-> (col_q != ci_s1), "line store read/write collision")
	`DWC3_ASSERT_ALWAYS(a_col_bound, col_q <= CW'(MAX_WIDTH - 1), "column counter out of range")

endmodule

/* rtl/core/dwc3_mac.sv */
// ---------------------------------------------------------------------------
// dwc3_mac
// Nine-tap multiply, bias add, rounding, saturation and activation.
// ---------------------------------------------------------------------------
`include "depthwise_conv3x3_stream_unit_defines.svh"

module dwc3_mac
	import dwc3_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             win_valid,
	output logic             win_ready,
	input  win_t             win,
	input  coef_t            coef,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [PIX_W-1:0] out_value,
	output logic             out_last
);

	logic                         v2_s2, v3_s3, v4_s4, o_valid_q;
	logic                         rdy2, rdy3, rdy4, o_rdy;
	logic                         last_s2, last_s3, last_s4, o_last_q;
	logic signed [PROD_W-1:0]     prod_s2 [TAPS];
	logic signed [ROW_W-1:0]      row_s3 [KERNEL_SIZE];
	logic signed [Q_W-1:0]        q_s4;
	logic signed [ACC_W-1:0]      acc;
	logic signed [ROW_W-1:0]      bias_x;
	logic signed [PIX_W-1:0]      sat, res, clip;
	logic [PIX_W-1:0]             o_value_q;

	assign o_rdy     = !o_valid_q || out_ready;
	assign rdy4      = !v4_s4 || o_rdy;
	assign rdy3      = !v3_s3 || rdy4;
	assign rdy2      = !v2_s2 || rdy3;
	assign win_ready = rdy2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v2_s2     <= 1'b0;
			v3_s3     <= 1'b0;
			v4_s4     <= 1'b0;
			o_valid_q <= 1'b0;
		end else begin
			if (rdy2) v2_s2 <= win_valid;
			if (rdy3) v3_s3 <= v2_s2;
			if (rdy4) v4_s4 <= v3_s3;
			if (o_rdy) o_valid_q <= v4_s4;
		end
	end

	assign bias_x = ROW_W'($signed(coef.bias));
	assign acc    = ACC_W'(row_s3[0]) + ACC_W'(row_s3[1]) + ACC_W'(row_s3[2]) +
		ACC_W'(2048);

	always_comb begin
		if (q_s4 > Q_W'(32767)) begin
			sat = 16'sh7fff;
		end else if (q_s4 < -Q_W'(32768)) begin
			sat = -16'sh8000;
		end else begin
			sat = q_s4[PIX_W-1:0];
		end
		clip = $signed({coef.act, 8'h00});
		res  = sat;
		if (!coef.act[7]) begin
			if (sat < 0) begin
				res = '0;
			end else if ((coef.act != 8'd0) && (sat > clip)) begin
				res = clip;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2 && win_valid) begin
			for (int k = 0; k < TAPS; k++) begin
				prod_s2[k] <= $signed(win.taps[k]) * $signed(coef.weight[k]);
			end
			last_s2 <= win.last;
		end
		if (rdy3 && v2_s2) begin
			for (int r = 0; r < KERNEL_SIZE; r++) begin
				row_s3[r] <= ROW_W'(prod_s2[KERNEL_SIZE*r]) +
					ROW_W'(prod_s2[KERNEL_SIZE*r+1]) +
					ROW_W'(prod_s2[KERNEL_SIZE*r+2]) +
					((r == KERNEL_SIZE - 1) ? bias_x : ROW_W'(0));
			end
			last_s3 <= last_s2;
		end
		if (rdy4 && v3_s3) begin
			q_s4    <= acc[ACC_W-1:FRAC_SHIFT];
			last_s4 <= last_s3;
		end
		if (o_rdy && v4_s4) begin
			o_value_q <= res;
			o_last_q  <= last_s4;
		end
	end

	assign out_valid = o_valid_q;
	assign out_value = o_value_q;
	assign out_last  = o_last_q;

	`DWC3_ASSERT(a_s4_hold, (v4_s4 && !o_rdy) |=> v4_s4, "stage 4 item dropped under stall")
	`DWC3_ASSERT(a_out_load, (v4_s4 && o_rdy) |=> o_valid_q, "stage 4 item not moved to output")

endmodule

/* test/tb_top.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Feeds Q8.8 planes through the depthwise 3x3 stream unit while
// both stream sides stall at random, and compares every output pixel and its
// plane-end flag with a bit-accurate window predictor kept in step with the
// accepted pixel requests and register writes.
// ---------------------------------------------------------------------------
module tb_top;
	import dwc3_pkg::*;

	localparam int CLK_HALF      = 6;
	localparam int RESET_CYCLES  = 9;
	localparam int SETTLE_CYCLES = 16;
	localparam int LONG_HOLD     = 240;
	localparam int RANDOM_PIXELS = 200;
	localparam int QUIET_TAIL    = 60;
	localparam int CYCLE_LIMIT   = 400000;

	localparam logic [15:0] EXTREME_PIX [5] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001};

	typedef enum int {PIX_FULL, PIX_SMALL, PIX_EDGE, PIX_MAX, PIX_MIN} pix_mode_t;

	typedef struct packed {
		logic [15:0] value;
		logic        last;
	} conv_out_t;

	class conv_checker;
		logic signed [15:0] weight [3][3];
		logic signed [31:0] bias;
		logic [10:0]        width_cfg;
		logic [10:0]        height_cfg;
		logic               stride_two;
		logic signed [7:0]  act;
		logic [15:0]        row_above [DWC3_MAX_WIDTH];
		logic [15:0]        row_above2 [DWC3_MAX_WIDTH];
		logic signed [15:0] window [6];
		int unsigned        col_cnt;
		int unsigned        row_cnt;
		conv_out_t          outputs_due [$];
		int                 pixels_seen;
		int                 outputs_seen;
		int                 errors;

		function new();
			foreach (weight[i, j])
				weight[i][j] = '0;
			foreach (row_above[i]) begin
				row_above[i]  = '0;
				row_above2[i] = '0;
			end
			foreach (window[i])
				window[i] = '0;
			bias         = '0;
			width_cfg    = 11'd3;
			height_cfg   = 11'd3;
			stride_two   = 1'b0;
			act          = -8'sd1;
			col_cnt      = 0;
			row_cnt      = 0;
			pixels_seen  = 0;
			outputs_seen = 0;
			errors       = 0;
		endfunction

		function int unsigned clamp_dim(logic [10:0] v, int unsigned hi);
			if (v < 3)
				return 3;
			if (v > hi)
				return hi;
			return v;
		endfunction

		function bit at_plane_start();
			return (col_cnt == 0) && (row_cnt == 0);
		endfunction

		function void write_reg(cfg_reg_t idx, logic [47:0] d);
			case (idx)
				REG_WEIGHT_ROW0, REG_WEIGHT_ROW1, REG_WEIGHT_ROW2: begin
					for (int j = 0; j < 3; j++)
						weight[int'(idx)][j] = d[16*j +: 16];
				end
				REG_BIAS:       bias       = d[31:0];
				REG_WIDTH:      width_cfg  = d[10:0];
				REG_HEIGHT:     height_cfg = d[10:0];
				REG_STRIDE:     stride_two = d[0];
				REG_ACTIVATION: act        = d[7:0];
				default: ;
			endcase
		endfunction

		function void note_pixel(logic [15:0] px);
			int unsigned        w, h, ci, last_c, last_r;
			logic signed [15:0] column [3];
			longint             acc;
			bit                 emit;
			conv_out_t          res;
			w  = clamp_dim(width_cfg, DWC3_MAX_WIDTH);
			h  = clamp_dim(height_cfg, DWC3_MAX_HEIGHT);
			ci = (col_cnt < DWC3_MAX_WIDTH) ? col_cnt : DWC3_MAX_WIDTH - 1;
			column[0] = row_above2[ci];
			column[1] = row_above[ci];
			column[2] = px;
			emit = (row_cnt >= 2) && (col_cnt >= 2);
			if (stride_two && (((row_cnt | col_cnt) & 1) != 0))
				emit = 1'b0;
			if (emit) begin
				acc = longint'(bias);
				for (int i = 0; i < 3; i++) begin
					acc += longint'(window[2*i]) * longint'(weight[i][0]);
					acc += longint'(window[2*i+1]) * longint'(weight[i][1]);
					acc += longint'(column[i]) * longint'(weight[i][2]);
				end
				// round half up, then floor to Q8.8
				acc = (acc + 2048) >>> FRAC_SHIFT;
				if (acc > 32767)
					acc = 32767;
				if (acc < -32768)
					acc = -32768;
				if (act >= 0) begin
					if (acc < 0)
						acc = 0;
					if (act > 0 && acc > longint'(act) * 256)
						acc = longint'(act) * 256;
				end
				if (stride_two) begin
					last_c = 2 + 2 * ((w - 3) / 2);
					last_r = 2 + 2 * ((h - 3) / 2);
				end else begin
					last_c = w - 1;
					last_r = h - 1;
				end
				res.value = acc[15:0];
				res.last  = (col_cnt == last_c) && (row_cnt == last_r);
				outputs_due.push_back(res);
			end
			window[0] = window[1];
			window[1] = column[0];
			window[2] = window[3];
			window[3] = column[1];
			window[4] = window[5];
			window[5] = column[2];
			row_above2[ci] = column[1];
			row_above[ci]  = px;
			if (col_cnt >= w - 1) begin
				col_cnt = 0;
				row_cnt = (row_cnt >= h - 1) ? 0 : row_cnt + 1;
			end else begin
				col_cnt++;
			end
			pixels_seen++;
		endfunction

		function void check_output(logic [15:0] value, logic last);
			conv_out_t exp_out;
			outputs_seen++;
			if (outputs_due.size() == 0) begin
				$error("output with nothing pending: result_value %h plane_last %b", value, last);
				errors++;
				return;
			end
			exp_out = outputs_due.pop_front();
			if (value !== exp_out.value) begin
				$error("result_value: expected %h, actual %h", exp_out.value, value);
				errors++;
			end
			if (last !== exp_out.last) begin
				$error("plane_last: expected %b, actual %b", exp_out.last, last);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n        = 1'b0;
	logic        cfg_valid     = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index     = '0;
	logic [47:0] cfg_data      = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata  = '0;  // [15:0] pixel
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;        // [15:0] result_value
	logic        m_axis_tlast;        // plane_last

	conv_checker sb = new();
	bit          quiet = 1'b0;
	bit          hold_req = 1'b0;
	int          settings_done = 0;

	depthwise_conv3x3_stream_unit DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin : clock_gen
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	function automatic logic [15:0] pick_pixel(pix_mode_t mode);
		case (mode)
			PIX_SMALL: return 16'($urandom_range(0, 1023) - 512);
			PIX_EDGE:  return EXTREME_PIX[$urandom_range(0, 4)];
			PIX_MAX:   return 16'h7FFF;
			PIX_MIN:   return 16'h8000;
			default:   return 16'($urandom());
		endcase
	endfunction

	function automatic logic [47:0] random_weight_row();
		logic [47:0] row;
		for (int j = 0; j < 3; j++)
			row[16*j +: 16] = ($urandom_range(0, 2) == 0) ? 16'($urandom())
				: 16'($urandom_range(0, 8191) - 4096);
		return row;
	endfunction

	task automatic send_pixel(input logic [15:0] px);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= px;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_pixel(px);
	endtask

	// runs on until the counters are back at the top-left corner
	task automatic send_plane(input pix_mode_t mode);
		do send_pixel(pick_pixel(mode)); while (!sb.at_plane_start());
	endtask

	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (sb.outputs_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic put_cfg(input cfg_reg_t idx, input logic [47:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, d);
	endtask

	task automatic apply_setting(input logic [47:0] row0, row1, row2, input logic [31:0] bias,
		input int width, height, input bit stride, input int act, input bit noisy);
		logic [47:0] noise;
		noise = noisy ? {16'($urandom()), 32'($urandom())} : '0;
		settle();
		put_cfg(REG_WEIGHT_ROW0, row0);
		put_cfg(REG_WEIGHT_ROW1, row1);
		put_cfg(REG_WEIGHT_ROW2, row2);
		put_cfg(REG_BIAS, {noise[47:32], bias});
		put_cfg(REG_WIDTH, {noise[47:11], width[10:0]});
		put_cfg(REG_HEIGHT, {noise[47:11], height[10:0]});
		put_cfg(REG_STRIDE, {noise[47:1], stride});
		put_cfg(REG_ACTIVATION, {noise[47:8], act[7:0]});
		cfg_valid <= 1'b0;
		settings_done++;
	endtask

	task automatic random_setting();
		logic [31:0] bias;
		int          width, height, act;
		bias   = $urandom_range(0, 1) ? $urandom() : 32'($urandom_range(0, 2097151) - 1048576);
		width  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
		height = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
		case ($urandom_range(0, 3))
			0:       act = -1;
			1:       act = 0;
			2:       act = $urandom_range(1, 127);
			default: act = -int'($urandom_range(2, 128));
		endcase
		apply_setting(random_weight_row(), random_weight_row(), random_weight_row(), bias,
			width, height, 1'($urandom_range(0, 1)), act, 1'($urandom_range(0, 1)));
	endtask

	initial begin : result_side
		int stall_left;
		int hold_left;
		stall_left = 0;
		hold_left  = 0;
		forever begin
			@(posedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready)
				sb.check_output(m_axis_tdata, m_axis_tlast);
			if (hold_req) begin
				hold_left = LONG_HOLD;
				hold_req  = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 4) == 0) begin
				stall_left = $urandom_range(1, 3) - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	initial begin : watchdog
		repeat (CYCLE_LIMIT) @(posedge clk);
		$error("timeout with %0d results pending", sb.outputs_due.size());
		$display("depthwise_conv3x3_stream_unit verification failed");
		$finish;
	end

	initial begin : stimulus
		int        random_start;
		int        planes;
		pix_mode_t mode;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// defaults after reset: zero kernel, 3x3 plane
		send_plane(PIX_EDGE);
		// saturation both ways
		apply_setting({3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}}, 32'h7FFF_FFFF,
			3, 3, 1'b0, -1, 1'b0);
		send_plane(PIX_MAX);
		apply_setting({3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}}, 32'h8000_0000,
			3, 3, 1'b0, -1, 1'b0);
		send_plane(PIX_MIN);
		// center tap 1.0: rounding at the half step, ReLU and clip
		apply_setting(48'h0, 48'h0000_1000_0000, 48'h0, 32'd2048, 3, 3, 1'b0, 0, 1'b0);
		send_plane(PIX_EDGE);
		apply_setting(48'h0, 48'h0000_1000_0000, 48'h0, 32'hFFFF_F7FF, 3, 4, 1'b0, 1, 1'b0);
		send_plane(PIX_FULL);
		// stride two, width below range, most negative kernel, clip at 127
		apply_setting({3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}}, 32'h0,
			0, 5, 1'b1, 127, 1'b1);
		send_plane(PIX_SMALL);

		// plane shrunk while in its fourth row
		apply_setting(random_weight_row(), random_weight_row(), random_weight_row(), 32'h0,
			6, 8, 1'b0, -1, 1'b0);
		repeat (20) send_pixel(pick_pixel(PIX_FULL));
		settle();
		put_cfg(REG_HEIGHT, 48'd3);
		put_cfg(REG_WIDTH, 48'd3);
		cfg_valid <= 1'b0;
		send_plane(PIX_FULL);

		// wide plane and tall stride-two plane
		apply_setting(random_weight_row(), random_weight_row(), random_weight_row(), $urandom(),
			40, 3, 1'b0, -1, 1'b0);
		send_plane(PIX_FULL);
		apply_setting(random_weight_row(), random_weight_row(), random_weight_row(), $urandom(),
			4, 21, 1'b1, 5, 1'b0);
		send_plane(PIX_SMALL);

		// output held off while a plane keeps streaming in
		apply_setting(random_weight_row(), random_weight_row(), random_weight_row(), $urandom(),
			12, 6, 1'b0, -1, 1'b0);
		hold_req = 1'b1;
		send_plane(PIX_FULL);

		random_start = sb.pixels_seen;
		while (sb.pixels_seen - random_start < RANDOM_PIXELS) begin
			quiet = (sb.pixels_seen - random_start > RANDOM_PIXELS - QUIET_TAIL)
				|| ($urandom_range(0, 3) == 0);
			random_setting();
			planes = $urandom_range(1, 3);
			repeat (planes) begin
				case ($urandom_range(0, 5))
					0:       mode = PIX_EDGE;
					1, 2:    mode = PIX_SMALL;
					default: mode = PIX_FULL;
				endcase
				send_plane(mode);
			end
		end
		settle();

		$display("%0d pixel requests, %0d results checked over %0d register settings",
			sb.pixels_seen, sb.outputs_seen, settings_done);
		$display("planes 3 to 40 wide and 3 to 21 tall, both strides, all activation modes, mid-plane resize");
		if (sb.errors == 0)
			$display("depthwise_conv3x3_stream_unit verification clean");
		else
			$display("depthwise_conv3x3_stream_unit verification failed");
		$finish;
	end

endmodule
